// File: hdl/kmv_pkg.sv
// Shared constants and control bundles for the KMV distinct-count estimator.
`timescale 1ns / 1ps
package kmv_pkg;

  localparam int MAX_KEEP = 256;
  localparam int HASH_W   = 64;
  localparam int CNT_W    = $clog2(MAX_KEEP + 1);
  localparam int ADDR_W   = $clog2(MAX_KEEP);
  localparam int TOTAL_W  = 48;
  localparam int DIVR_W   = 32;
  localparam int STEP_W   = $clog2(HASH_W);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};
  localparam logic [CNT_W-1:0]   KEEP_MAX    = CNT_W'(MAX_KEEP);
  localparam logic [CNT_W-1:0]   LIMIT_RESET = CNT_W'(MAX_KEEP);

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] hash;
    logic [CNT_W-1:0]  limit;
  } kmv_heap_req_t;

  typedef struct packed {
    logic              done;
    logic [CNT_W-1:0]  count;
    logic [HASH_W-1:0] root;
  } kmv_heap_stat_t;

endpackage

// File: hdl/kmv_distinct_count_estimator.sv
// Top level of the KMV distinct-count estimator: control, estimate datapath, ports.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall / in_hash_value) takes one 64-bit element
//   hash per word. Output channel (out_valid / out_stall / out_*) returns one
//   word per input: estimate, saturating total and number of kept hashes.
//   cfg_we / cfg_data write keep_limit (reset 256, values above 256 act as 256,
//   zero disables tracking); write it only while the block is idle.
// Operation:
//   One word at a time. The duplicate scan walks the kept store through its
//   single read port, one entry a cycle, then a heap sift runs over at most
//   8 levels. Once the kept count reaches the limit, the estimate runs the
//   64-step divider, then the rescale and the clamp to the total.
// Reset:
//   Synchronous, active low. Clears the kept count, the total and the output
//   valid; the hash store itself is not cleared, only counted entries are read.
// Backpressure:
//   in_stall is high while a word is being worked on. A finished result sits
//   in the output register while out_stall is high; a new input word is taken
//   meanwhile and its result waits until the output register is free.
module kmv_distinct_count_estimator
  import kmv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [HASH_W-1:0]  in_hash_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TOTAL_W-1:0] out_estimate,
  output logic [TOTAL_W-1:0] out_total_added,
  output logic [CNT_W-1:0]   out_kept_count,
  input  logic               cfg_we,
  input  logic [CNT_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_HEAP, S_PREP, S_DIV, S_FIXA, S_FIXB, S_FINISH
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   limit_r, limit_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W-1:0] est_r, est_nxt;
  logic signed [7:0]  renorm_r, renorm_nxt;
  logic [HASH_W-1:0]  q_r, q_nxt;
  logic [HASH_W-1:0]  sh_r, sh_nxt;
  logic               over_r, over_nxt;
  logic               ov_r, ov_nxt;
  logic [TOTAL_W-1:0] oe_r, oe_nxt;
  logic [TOTAL_W-1:0] ot_r, ot_nxt;
  logic [CNT_W-1:0]   ok_r, ok_nxt;

  logic [CNT_W-1:0]   lim_eff;
  logic               accept;
  kmv_heap_req_t      hreq;
  kmv_heap_stat_t     hstat;

  logic               div_start;
  logic               div_done;
  logic [HASH_W-1:0]  div_quo;
  logic [HASH_W-1:0]  div_num;
  logic [DIVR_W-1:0]  div_den;

  logic [3:0]         zbytes;
  logic [3:0]         msb;
  logic [HASH_W-1:0]  root_sh;
  logic [DIVR_W-1:0]  norm_n;
  logic [DIVR_W-1:0]  top_word;
  logic [4:0]         rsh;
  logic [6:0]         lsh;
  logic [TOTAL_W-1:0] cap;
  logic [HASH_W-1:0]  pick;

  assign lim_eff  = (limit_r > KEEP_MAX) ? KEEP_MAX : limit_r;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign hreq.start = accept;
  assign hreq.hash  = in_hash_value;
  assign hreq.limit = lim_eff;

  kmv_heap u_heap (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (hreq),
    .stat (hstat)
  );

  // leading zero bytes of the root and floor(log2) of the kept count
  always_comb begin
    zbytes = 4'd8;
    for (int b = 0; b < 8; b++) begin
      if (hstat.root[8*b +: 8] != 8'd0) begin
        zbytes = 4'(7 - b);
      end
    end
    msb = 4'd0;
    for (int k = 0; k < CNT_W; k++) begin
      if (hstat.count[k]) begin
        msb = 4'(k);
      end
    end
  end

  assign root_sh  = hstat.root << {zbytes, 3'b000};
  assign top_word = root_sh[HASH_W-1:DIVR_W];
  assign norm_n   = {{(DIVR_W-CNT_W){1'b0}}, hstat.count} << (5'd31 - {1'b0, msb});
  assign div_num  = {norm_n, {DIVR_W{1'b0}}};
  assign div_den  = (top_word == '0) ? DIVR_W'(1) : top_word;
  assign div_start = (state_r == S_PREP);

  kmv_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_num),
    .divisor (div_den),
    .done    (div_done),
    .quotient(div_quo)
  );

  // rescale: renorm < 0 shifts right, otherwise shift left with an overflow cap
  assign rsh  = 5'(-renorm_r);
  assign lsh  = renorm_r[6:0];
  assign cap  = total_r >> lsh;
  assign pick = over_r ? {{(HASH_W-TOTAL_W){1'b0}}, total_r} : sh_r;

  always_comb begin
    state_nxt  = state_r;
    limit_nxt  = cfg_we ? cfg_data : limit_r;
    total_nxt  = total_r;
    est_nxt    = est_r;
    renorm_nxt = renorm_r;
    q_nxt      = q_r;
    sh_nxt     = sh_r;
    over_nxt   = over_r;
    ov_nxt     = ov_r;
    oe_nxt     = oe_r;
    ot_nxt     = ot_r;
    ok_nxt     = ok_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (total_r != TOTAL_MAX) begin
            total_nxt = total_r + TOTAL_W'(1);
          end
          state_nxt = S_HEAP;
        end
      end
      S_HEAP: begin
        if (hstat.done) begin
          if (lim_eff == '0) begin
            est_nxt   = '0;
            state_nxt = S_FINISH;
          end else if (hstat.count < lim_eff) begin
            est_nxt   = TOTAL_W'(hstat.count);
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        renorm_nxt = $signed({1'b0, zbytes, 3'b000}) - $signed(8'd31 - {4'd0, msb});
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          q_nxt     = div_quo;
          state_nxt = S_FIXA;
        end
      end
      S_FIXA: begin
        if (renorm_r < 0) begin
          sh_nxt   = q_r >> rsh;
          over_nxt = 1'b0;
        end else begin
          sh_nxt   = q_r << lsh;
          over_nxt = q_r > {{(HASH_W-TOTAL_W){1'b0}}, cap};
        end
        state_nxt = S_FIXB;
      end
      S_FIXB: begin
        // clamp to the total
        if (pick > {{(HASH_W-TOTAL_W){1'b0}}, total_r}) begin
          est_nxt = total_r;
        end else begin
          est_nxt = pick[TOTAL_W-1:0];
        end
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          oe_nxt    = est_r;
          ot_nxt    = total_r;
          ok_nxt    = hstat.count;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= LIMIT_RESET;
      total_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      limit_r <= limit_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
    est_r    <= est_nxt;
    renorm_r <= renorm_nxt;
    q_r      <= q_nxt;
    sh_r     <= sh_nxt;
    over_r   <= over_nxt;
    oe_r     <= oe_nxt;
    ot_r     <= ot_nxt;
    ok_r     <= ok_nxt;
  end

  assign out_valid       = ov_r;
  assign out_estimate    = oe_r;
  assign out_total_added = ot_r;
  assign out_kept_count  = ok_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall) else $error("input taken while word in flight");

  a_est_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> oe_r <= ot_r) else $error("estimate above total");

  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> total_r >= $past(total_r)) else $error("total went down");

endmodule

// File: hdl/kmv_div.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 32-bit divisor.
`timescale 1ns / 1ps
module kmv_div
  import kmv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic              done,
  output logic [HASH_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [HASH_W-1:0] quo_r, quo_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIVR_W-1:0] dsr_r, dsr_nxt;
  logic [DIVR_W:0]   trial;
  logic              fits;

  assign trial = {rem_r, quo_r[HASH_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // shift in next dividend bit, subtract when it fits
      rem_nxt = fits ? DIVR_W'(trial - {1'b0, dsr_r}) : trial[DIVR_W-1:0];
      quo_nxt = {quo_r[HASH_W-2:0], fits};
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_W'(HASH_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hdl/kmv_heap.sv
// Kept-hash store: duplicate scan, sift-up insert and root-replace sift-down.
`timescale 1ns / 1ps
module kmv_heap
  import kmv_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  kmv_heap_req_t  req,
  output kmv_heap_stat_t stat
);

  typedef enum logic [3:0] {
    H_IDLE, H_SEARCH, H_DECIDE, H_UP, H_UP_CMP,
    H_DN, H_DN_L, H_DN_R, H_DN_CMP
  } h_state_t;

  h_state_t          state_r, state_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [CNT_W-1:0]  lim_r, lim_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              chk_r, chk_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [ADDR_W-1:0] child_r, child_nxt;
  logic [HASH_W-1:0] cv_r, cv_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [HASH_W-1:0] root_r, root_nxt;
  logic              done_r, done_nxt;

  logic [HASH_W-1:0] mem [MAX_KEEP];
  logic [HASH_W-1:0] rdata_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [HASH_W-1:0] wd;
  logic [CNT_W-1:0]  child_l;
  logic [CNT_W-1:0]  child_rt;

  assign child_l  = {pos_r, 1'b1};
  assign child_rt = {1'b0, child_r} + CNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    hash_nxt  = hash_r;
    lim_nxt   = lim_r;
    idx_nxt   = idx_r;
    chk_nxt   = chk_r;
    pos_nxt   = pos_r;
    child_nxt = child_r;
    cv_nxt    = cv_r;
    count_nxt = count_r;
    done_nxt  = 1'b0;
    rd_addr   = idx_r[ADDR_W-1:0];
    we        = 1'b0;
    wa        = pos_r;
    wd        = hash_r;
    unique case (state_r)
      H_IDLE: begin
        if (req.start) begin
          hash_nxt = req.hash;
          lim_nxt  = req.limit;
          idx_nxt  = '0;
          chk_nxt  = 1'b0;
          if (req.limit == '0) begin
            done_nxt = 1'b1;
          end else begin
            state_nxt = H_SEARCH;
          end
        end
      end
      H_SEARCH: begin
        // issue one read a cycle, compare the word read the cycle before
        if (chk_r && rdata_r == hash_r) begin
          done_nxt  = 1'b1;
          state_nxt = H_IDLE;
        end else if (idx_r < count_r) begin
          rd_addr = idx_r[ADDR_W-1:0];
          idx_nxt = idx_r + CNT_W'(1);
          chk_nxt = 1'b1;
        end else begin
          chk_nxt   = 1'b0;
          state_nxt = H_DECIDE;
        end
      end
      H_DECIDE: begin
        if (count_r < lim_r) begin
          pos_nxt   = count_r[ADDR_W-1:0];
          state_nxt = H_UP;
        end else if (count_r != '0 && hash_r < root_r) begin
          pos_nxt   = '0;
          state_nxt = H_DN;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = H_IDLE;
        end
      end
      H_UP: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          done_nxt  = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          rd_addr   = (pos_r - ADDR_W'(1)) >> 1;
          child_nxt = rd_addr;
          state_nxt = H_UP_CMP;
        end
      end
      H_UP_CMP: begin
        we = 1'b1;
        if (hash_r > rdata_r) begin
          wd        = rdata_r;
          pos_nxt   = child_r;
          state_nxt = H_UP;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          done_nxt  = 1'b1;
          state_nxt = H_IDLE;
        end
      end
      H_DN: begin
        if (child_l >= count_r) begin
          we        = 1'b1;
          done_nxt  = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          rd_addr   = child_l[ADDR_W-1:0];
          child_nxt = child_l[ADDR_W-1:0];
          state_nxt = H_DN_L;
        end
      end
      H_DN_L: begin
        cv_nxt = rdata_r;
        if (child_rt < count_r) begin
          rd_addr   = child_rt[ADDR_W-1:0];
          state_nxt = H_DN_R;
        end else begin
          state_nxt = H_DN_CMP;
        end
      end
      H_DN_R: begin
        if (rdata_r > cv_r) begin
          cv_nxt    = rdata_r;
          child_nxt = child_rt[ADDR_W-1:0];
        end
        state_nxt = H_DN_CMP;
      end
      H_DN_CMP: begin
        we = 1'b1;
        if (cv_r > hash_r) begin
          wd        = cv_r;
          pos_nxt   = child_r;
          state_nxt = H_DN;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = H_IDLE;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
    root_nxt = (we && wa == '0) ? wd : root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      count_r <= '0;
      done_r  <= 1'b0;
      chk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      done_r  <= done_nxt;
      chk_r   <= chk_nxt;
    end
    hash_r  <= hash_nxt;
    lim_r   <= lim_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    child_r <= child_nxt;
    cv_r    <= cv_nxt;
    root_r  <= root_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[rd_addr];
  end

  assign stat.done  = done_r;
  assign stat.count = count_r;
  assign stat.root  = root_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= KEEP_MAX) else $error("kept count above store depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(count_r) |-> count_r == $past(count_r) + CNT_W'(1))
    else $error("kept count moved by other than one");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == H_IDLE) else $error("heap started while busy");

endmodule

// File: tb/sv/tb_kmv_distinct_count_estimator.sv
// Testbench for the KMV distinct-count estimator: directed and random hashes, scoreboard.
`timescale 1ns / 1ps
module tb_kmv_distinct_count_estimator
  import kmv_pkg::*;
();

  // Estimate word predicted for one accepted hash.
  typedef struct {
    logic [TOTAL_W-1:0] estimate;
    logic [TOTAL_W-1:0] total;
    logic [CNT_W-1:0]   kept;
  } kmv_word_t;

  // Scoreboard: holds its own copy of the kept set, the total and the limit,
  // and queues the expected output word for every accepted input word.
  class kmv_scoreboard;
    logic [HASH_W-1:0]  kept_heap[MAX_KEEP];
    int unsigned        kept_n;
    logic [TOTAL_W-1:0] total;
    int unsigned        limit;
    kmv_word_t          pending[$];
    int unsigned        errors;

    function void clear();
      kept_n = 0;
      total  = '0;
      limit  = MAX_KEEP;
      pending.delete();
      errors = 0;
    endfunction

    function void set_limit(logic [CNT_W-1:0] v);
      limit = (v > MAX_KEEP) ? MAX_KEEP : v;
    endfunction

    function void sift_up(int unsigned pos);
      logic [HASH_W-1:0] v;
      int unsigned up;
      v = kept_heap[pos];
      while (pos != 0) begin
        up = (pos - 1) >> 1;
        if (!(v > kept_heap[up])) break;
        kept_heap[pos] = kept_heap[up];
        pos = up;
      end
      kept_heap[pos] = v;
    endfunction

    function void sift_down();
      logic [HASH_W-1:0] v;
      logic [HASH_W-1:0] cv;
      int unsigned pos;
      int unsigned child;
      pos = 0;
      v = kept_heap[0];
      forever begin
        child = 2 * pos + 1;
        if (child >= kept_n) break;
        cv = kept_heap[child];
        if (child + 1 < kept_n && kept_heap[child + 1] > cv) begin
          child++;
          cv = kept_heap[child];
        end
        if (!(cv > v)) break;
        kept_heap[pos] = cv;
        pos = child;
      end
      kept_heap[pos] = v;
    endfunction

    function logic [TOTAL_W-1:0] cardinality();
      logic [HASH_W-1:0] root;
      logic [HASH_W-1:0] d;
      logic [HASH_W-1:0] q;
      logic [HASH_W-1:0] tot;
      logic [31:0] nsh;
      int z;
      int m;
      int renorm;
      if (limit == 0) return '0;
      if (kept_n < limit) return TOTAL_W'(kept_n);
      root = kept_heap[0];
      z = 0;
      while (z < 8 && root[63 - 8 * z -: 8] == 8'h00) z++;
      d = (z < 8) ? ((root << (8 * z)) >> 32) : 64'd0;
      if (d == 0) d = 1;
      m = 0;
      while (m < 31 && (kept_n >> (m + 1)) != 0) m++;
      nsh = 32'(kept_n << (31 - m));
      q = {nsh, 32'h0} / d;
      tot = {16'h0, total};
      renorm = 8 * z - (31 - m);
      if (renorm < 0) begin
        q = q >> (-renorm);
      end else begin
        if (q > (tot >> renorm)) return total;
        q = q << renorm;
      end
      if (q > tot) return total;
      return q[TOTAL_W-1:0];
    endfunction

    function void note_hash(logic [HASH_W-1:0] h);
      kmv_word_t w;
      bit dup;
      dup = 0;
      if (total != TOTAL_MAX) total++;
      if (limit != 0) begin
        for (int i = 0; i < kept_n; i++)
          if (kept_heap[i] == h) dup = 1;
        if (!dup) begin
          if (kept_n < limit) begin
            kept_heap[kept_n] = h;
            sift_up(kept_n);
            kept_n++;
          end else if (kept_n > 0 && h < kept_heap[0]) begin
            kept_heap[0] = h;
            sift_down();
          end
        end
      end
      w.estimate = cardinality();
      w.total    = total;
      w.kept     = CNT_W'(kept_n);
      pending = {pending, w};
    endfunction

    function void check_word(logic [TOTAL_W-1:0] est, logic [TOTAL_W-1:0] tot,
                             logic [CNT_W-1:0] kc);
      kmv_word_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output word est=%0d total=%0d kept=%0d",
                 $time, est, tot, kc);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (est !== w.estimate) begin
        $display("%0t: estimate expected %0d actual %0d", $time, w.estimate, est);
        errors++;
      end
      if (tot !== w.total) begin
        $display("%0t: total_added expected %0d actual %0d", $time, w.total, tot);
        errors++;
      end
      if (kc !== w.kept) begin
        $display("%0t: kept_count expected %0d actual %0d", $time, w.kept, kc);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [HASH_W-1:0]  in_hash_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [TOTAL_W-1:0] out_estimate;
  logic [TOTAL_W-1:0] out_total_added;
  logic [CNT_W-1:0]   out_kept_count;
  logic               cfg_we = 1'b0;
  logic [CNT_W-1:0]   cfg_data = '0;

  kmv_scoreboard sb = new();

  // Idling knobs: quiet turns both sides' gaps off for the last part of the run.
  bit quiet = 0;
  bit hold_out = 0;
  int unsigned idle_cycles = 0;
  localparam int unsigned IDLE_LIMIT = 20000;

  always #5 clk = ~clk;

  kmv_distinct_count_estimator u_top (.*);

  // Watchdog: count cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_kmv_distinct_count_estimator failed");
      $finish;
    end
  end

  // Check every accepted output word at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_estimate, out_total_added, out_kept_count);
  end

  // Receiver stall: random bursts, or a long hold when asked.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one hash; hold it until accepted, then note it and drop valid.
  task automatic send_hash(logic [HASH_W-1:0] h);
    if (!quiet && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 14)) @(negedge clk);
    else
      @(negedge clk);
    in_valid <= 1'b1;
    in_hash_value <= h;
    do @(posedge clk); while (in_stall);
    sb.note_hash(h);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait until every expected word has come back and the block has settled.
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(v);
  endtask

  function automatic logic [HASH_W-1:0] rand_hash();
    logic [HASH_W-1:0] h;
    h = {$urandom, $urandom};
    // Push some hashes toward many leading zero bytes.
    if ($urandom_range(0, 3) == 0) h = h >> (8 * $urandom_range(1, 8));
    return h;
  endfunction

  // One phase of random hashes; repeat some to exercise duplicates.
  task automatic random_phase(int count);
    logic [HASH_W-1:0] seen[$];
    logic [HASH_W-1:0] h;
    for (int i = 0; i < count; i++) begin
      if (seen.size() != 0 && $urandom_range(0, 3) == 0)
        h = seen[$urandom_range(0, seen.size() - 1)];
      else
        h = rand_hash();
      if (seen.size() < 64) seen = {seen, h};
      send_hash(h);
    end
  endtask

  initial begin
    sb.clear();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, a duplicate, a zero hash into a tiny full heap.
    write_limit(9'd2);
    send_hash('0);
    send_hash('1);
    send_hash('1);
    send_hash(64'h0000_0000_0000_0001);
    send_hash(64'h8000_0000_0000_0000);
    send_hash('0);
    // Lower the limit below the kept count: heap stays as it is.
    write_limit(9'd1);
    send_hash(64'h0000_0000_0000_0000);
    send_hash(64'hFFFF_FFFF_FFFF_FFFE);
    // Zero disables tracking.
    write_limit(9'd0);
    send_hash(64'h5555_5555_5555_5555);
    send_hash(64'hAAAA_AAAA_AAAA_AAAA);
    // Above the store depth acts as the depth.
    write_limit(9'h1FF);
    send_hash(64'h0000_00FF_0000_0001);
    send_hash(64'h00FF_FFFF_FFFF_FFFF);

    // Random phases over several limits.
    write_limit(9'd3);
    random_phase(250);
    write_limit(9'd17);
    random_phase(300);

    // Long receiver hold while the sender keeps offering words.
    fork
      begin
        hold_out = 1;
        repeat (3000) @(negedge clk);
        hold_out = 0;
      end
      random_phase(30);
    join

    write_limit(9'd256);
    random_phase(700);
    write_limit(9'd64);
    random_phase(300);
    write_limit(9'd300);
    quiet = 1;
    random_phase(300);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_kmv_distinct_count_estimator passed");
    end else begin
      $display("tb_kmv_distinct_count_estimator failed");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/kmv_pkg.sv
hdl/kmv_div.sv
hdl/kmv_heap.sv
hdl/kmv_distinct_count_estimator.sv
tb/sv/tb_kmv_distinct_count_estimator.sv
